FILE: hdl/elf_segment_span_checker_assert.svh
// Assertion macros shared by the span checker RTL.
`ifndef ELF_SEGMENT_SPAN_CHECKER_ASSERT_SVH
`define ELF_SEGMENT_SPAN_CHECKER_ASSERT_SVH

// Plain implication, checked on every clock edge outside reset.
`define ESC_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ESC_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hdl/esc_pkg.sv
// Shared types and constants of the ELF segment span checker.
`timescale 1ns / 1ps

package esc_pkg;

	localparam logic [31:0] SEG_LOADABLE    = 32'd1;
	localparam logic [31:0] SEG_INTERP      = 32'd3;
	localparam logic [63:0] PAGE_MASK       = 64'h0000_0000_0000_0FFF;
	localparam logic [63:0] MIN_FIXED_START = 64'h0000_0000_0001_0000;
	localparam logic [63:0] INTERP_MIN      = 64'd2;
	localparam logic [63:0] INTERP_MAX      = 64'd256;
	localparam logic [63:0] ALL_ONES        = '1;

	// Queue between classifier and accumulator
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register map, 8 bytes per register
	localparam int PADDR_W = 5;

	typedef enum logic [1:0] {
		REG_IMG_LEN     = 2'd0,
		REG_RELOCATABLE = 2'd1,
		REG_PREF_BASE   = 2'd2
	} esc_reg_t;

	typedef struct packed {
		logic [63:0] img_len;
		logic        relocatable;
		logic [63:0] pref_base;
	} esc_cfg_t;

	// One classified header word
	typedef struct packed {
		logic        is_load;
		logic        fail;
		logic        last;
		logic [63:0] lo;
		logic [63:0] hi;
	} esc_item_t;

endpackage

FILE: hdl/esc_if.sv
// Header and result channel interfaces.
`timescale 1ns / 1ps

interface esc_hdr_if;
	logic        valid;
	logic        ready;
	logic [31:0] segment_type;
	logic [63:0] file_offset;
	logic [63:0] virt_addr;
	logic [63:0] file_bytes;
	logic [63:0] mem_bytes;
	logic [63:0] alignment;
	logic        last;

	modport source (output valid, segment_type, file_offset, virt_addr, file_bytes,
		mem_bytes, alignment, last, input ready);
	modport sink (input valid, segment_type, file_offset, virt_addr, file_bytes,
		mem_bytes, alignment, last, output ready);
endinterface

interface esc_res_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [63:0] span_start;
	logic [63:0] span_end;
	logic [63:0] reloc_bias;

	modport source (output valid, accepted, span_start, span_end, reloc_bias,
		input ready);
	modport sink (input valid, accepted, span_start, span_end, reloc_bias,
		output ready);
endinterface

FILE: hdl/esc_front.sv
// Front end: takes header words and classifies each one.
`timescale 1ns / 1ps

module esc_front (
	esc_hdr_if.sink            hdr,
	input  esc_pkg::esc_cfg_t  cfg,
	output logic               push,
	output esc_pkg::esc_item_t push_item,
	input  logic               push_ready
);

	logic        in_file;
	logic        interp_ok;
	logic        al_bad;
	logic        pg_bad;
	logic        ovf;
	logic        load_fail;
	logic [63:0] room;
	logic [63:0] end_round;

	assign hdr.ready = push_ready;
	assign push      = hdr.valid & push_ready;

	// Segment must lie inside the file
	assign room    = cfg.img_len - hdr.file_offset;
	assign in_file = (hdr.file_offset <= cfg.img_len) && (hdr.file_bytes <= room);

	assign interp_ok = (hdr.file_bytes >= esc_pkg::INTERP_MIN) &&
		(hdr.file_bytes <= esc_pkg::INTERP_MAX) && in_file;

	// Loadable checks
	assign al_bad = (hdr.alignment > 64'd1) &&
		((hdr.alignment & (hdr.alignment - 64'd1)) != 64'd0);
	assign pg_bad = (hdr.virt_addr[11:0] != hdr.file_offset[11:0]);
	assign ovf    = (hdr.virt_addr > ~hdr.mem_bytes);
	assign load_fail = (hdr.mem_bytes < hdr.file_bytes) || !in_file || al_bad ||
		pg_bad || ovf;

	// Page rounded end, wraps modulo 2^64
	assign end_round = hdr.virt_addr + hdr.mem_bytes + esc_pkg::PAGE_MASK;

	always_comb begin
		push_item.last = hdr.last;
		push_item.lo   = hdr.virt_addr & ~esc_pkg::PAGE_MASK;
		push_item.hi   = end_round & ~esc_pkg::PAGE_MASK;
		if (hdr.segment_type == esc_pkg::SEG_LOADABLE) begin
			push_item.is_load = 1'b1;
			push_item.fail    = load_fail;
		end else if (hdr.segment_type == esc_pkg::SEG_INTERP) begin
			push_item.is_load = 1'b0;
			push_item.fail    = !interp_ok;
		end else begin
			push_item.is_load = 1'b0;
			push_item.fail    = 1'b0;
		end
	end

endmodule

FILE: hdl/esc_queue.sv
// Short queue of classified words between front and back.
`timescale 1ns / 1ps

module esc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  esc_pkg::esc_item_t push_item,
	output logic               push_ready,
	input  logic               pop,
	output logic               pop_valid,
	output esc_pkg::esc_item_t pop_item
);

	esc_pkg::esc_item_t             slot_q [esc_pkg::QUEUE_DEPTH];
	logic [esc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [esc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [esc_pkg::QCNT_W-1:0]     count_q;

	assign push_ready = (count_q != esc_pkg::QCNT_W'(esc_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];

	function automatic logic [esc_pkg::QPTR_W-1:0] ptr_inc(
		input logic [esc_pkg::QPTR_W-1:0] p);
		if (p == esc_pkg::QPTR_W'(esc_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: hdl/esc_back.sv
// Back end: running span, image verdict and result register.
`timescale 1ns / 1ps

module esc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  esc_pkg::esc_cfg_t  cfg,
	input  logic               pop_valid,
	input  esc_pkg::esc_item_t pop_item,
	output logic               pop,
	esc_res_if.source          res
);

	// Per-image accumulators
	logic [63:0] low_q;
	logic [63:0] high_q;
	logic        saw_q;
	logic        rej_q;

	logic [63:0] nxt_low;
	logic [63:0] nxt_high;
	logic        nxt_saw;
	logic        nxt_rej;
	logic        take;

	// Finish stage
	logic        fin_vld_s1;
	logic        fin_pre_s1;
	logic [63:0] fin_lo_s1;
	logic [63:0] fin_hi_s1;
	logic        fin_adv;

	// Result register
	logic        out_vld_q;
	logic        out_ok_q;
	logic [63:0] out_start_q;
	logic [63:0] out_end_q;
	logic [63:0] out_bias_q;
	logic        out_load;
	logic        fin_ok;
	logic [63:0] fin_bias;

	assign out_load = !out_vld_q || res.ready;
	assign fin_adv  = fin_vld_s1 && out_load;
	assign pop = pop_valid && (!pop_item.last || !fin_vld_s1 || fin_adv);

	// A passing loadable word widens the span
	assign take     = !rej_q && !pop_item.fail && pop_item.is_load;
	assign nxt_rej  = rej_q | pop_item.fail;
	assign nxt_saw  = saw_q | pop_item.is_load;
	assign nxt_low  = (take && (pop_item.lo < low_q)) ? pop_item.lo : low_q;
	assign nxt_high = (take && (pop_item.hi > high_q)) ? pop_item.hi : high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= esc_pkg::ALL_ONES;
			high_q <= '0;
			saw_q  <= 1'b0;
			rej_q  <= 1'b0;
		end else if (pop) begin
			if (pop_item.last) begin
				low_q  <= esc_pkg::ALL_ONES;
				high_q <= '0;
				saw_q  <= 1'b0;
				rej_q  <= 1'b0;
			end else begin
				low_q  <= nxt_low;
				high_q <= nxt_high;
				saw_q  <= nxt_saw;
				rej_q  <= nxt_rej;
			end
		end
	end

	// Finish stage holds the closed span of one image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s1 <= 1'b0;
		end else if (pop && pop_item.last) begin
			fin_vld_s1 <= 1'b1;
		end else if (fin_adv) begin
			fin_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_item.last) begin
			fin_pre_s1 <= !nxt_rej && nxt_saw && (nxt_low != esc_pkg::ALL_ONES);
			fin_lo_s1  <= nxt_low;
			fin_hi_s1  <= nxt_high;
		end
	end

	// Base checks and bias
	always_comb begin
		fin_ok   = fin_pre_s1 && (fin_hi_s1 > fin_lo_s1);
		fin_bias = '0;
		if (cfg.relocatable) begin
			if (cfg.pref_base < fin_lo_s1)
				fin_ok = 1'b0;
			fin_bias = cfg.pref_base - fin_lo_s1;
		end else if (fin_lo_s1 < esc_pkg::MIN_FIXED_START) begin
			fin_ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fin_adv) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_adv) begin
			out_ok_q    <= fin_ok;
			out_start_q <= fin_ok ? fin_lo_s1 : 64'd0;
			out_end_q   <= fin_ok ? fin_hi_s1 : 64'd0;
			out_bias_q  <= fin_ok ? fin_bias : 64'd0;
		end
	end

	assign res.valid      = out_vld_q;
	assign res.accepted   = out_ok_q;
	assign res.span_start = out_start_q;
	assign res.span_end   = out_end_q;
	assign res.reloc_bias = out_bias_q;

endmodule

FILE: hdl/elf_segment_span_checker.sv
// Top level of the ELF64 program header span checker.
//
// Usage: program the file length, the relocatable flag and the preferred base
// over the APB port (byte addresses 0x00, 0x08, 0x10, 64-bit data) while the
// block is idle, then stream the program headers of one image on the hdr
// channel, one word per header, with last set on the final one. Only that
// final word gives a word on the res channel: the pass flag, the page span and
// the load bias, all fields zero on a reject. Then the next image may follow.
// Throughput: one header per clock cycle while the queue has room; hdr.ready
// drops while it is full.
// After the last header is accepted, it passes the queue, the finish stage and
// the result register, and then the result word is valid.
// Reset clears the queue, the registers and the span high mark to zero and
// sets the span low mark to all ones.
// When res stalls, the result register holds its word; headers keep flowing
// until the next image end meets a full finish stage, then the two-entry
// queue fills and hdr.ready drops.
`timescale 1ns / 1ps
`include "elf_segment_span_checker_assert.svh"

module elf_segment_span_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	esc_hdr_if.sink                     hdr,
	esc_res_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [esc_pkg::PADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);

	esc_pkg::esc_cfg_t  cfg_q;
	esc_pkg::esc_reg_t  reg_sel;
	logic               cfg_wr;

	logic               push;
	logic               push_ready;
	esc_pkg::esc_item_t push_item;
	logic               pop;
	logic               pop_valid;
	esc_pkg::esc_item_t pop_item;

	// Result properties
	logic               res_acc;
	logic               res_rej;
	logic               res_zero;
	logic               fix_acc;
	logic               floor_ok;

	// Register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = esc_pkg::esc_reg_t'(paddr[esc_pkg::PADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				esc_pkg::REG_IMG_LEN:     cfg_q.img_len     <= pwdata;
				esc_pkg::REG_RELOCATABLE: cfg_q.relocatable <= pwdata[0];
				esc_pkg::REG_PREF_BASE:   cfg_q.pref_base   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			esc_pkg::REG_IMG_LEN:     prdata = cfg_q.img_len;
			esc_pkg::REG_RELOCATABLE: prdata = {63'd0, cfg_q.relocatable};
			esc_pkg::REG_PREF_BASE:   prdata = cfg_q.pref_base;
			default:                  prdata = '0;
		endcase
	end

	esc_front u_front (
		.hdr        (hdr),
		.cfg        (cfg_q),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	esc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item)
	);

	esc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop),
		.res       (res)
	);

	// Checks
	assign res_acc  = res.valid && res.accepted;
	assign res_rej  = res.valid && !res.accepted;
	assign res_zero = (res.span_start == 64'd0) && (res.span_end == 64'd0) &&
		(res.reloc_bias == 64'd0);
	assign fix_acc  = res_acc && !cfg_q.relocatable;
	assign floor_ok = (res.span_start >= esc_pkg::MIN_FIXED_START) &&
		(res.reloc_bias == 64'd0);

	`ESC_ASSERT_IMP(a_rej_zero, res_rej, res_zero, "rejected result carries nonzero fields")
	`ESC_ASSERT_IMP(a_span_order, res_acc, res.span_end > res.span_start, "accepted span is empty")
	`ESC_ASSERT_IMP(a_fixed_floor, fix_acc, floor_ok, "fixed image below minimum start")
	`ESC_ASSERT_NXT(a_pop_nonempty, pop, 1'b1 && $past(pop_valid), "pop from empty queue")

endmodule

FILE: sim/tb.sv
// Self-checking testbench of the ELF segment span checker: directed images, then random ones.
`timescale 1ns / 1ps

module tb;

	localparam int RANDOM_ITEMS = 1900;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_SHOWN    = 10;

	typedef struct {
		logic [31:0] kind;
		logic [63:0] off;
		logic [63:0] vaddr;
		logic [63:0] fbytes;
		logic [63:0] mbytes;
		logic [63:0] align;
		logic        last;
	} hdr_word_t;

	typedef struct {
		logic        accepted;
		logic [63:0] span_start;
		logic [63:0] span_end;
		logic [63:0] reloc_bias;
	} verdict_t;

	typedef enum {HS_LOAD, HS_INTERP, HS_OTHER, HS_BROKEN, HS_NOISE} hdr_style_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [esc_pkg::PADDR_W-1:0] paddr;
	logic [63:0]                 pwdata;
	logic [63:0]                 prdata;
	logic                        pready;

	esc_hdr_if hdr_ch ();
	esc_res_if res_ch ();

	elf_segment_span_checker uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.hdr     (hdr_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Register shadows
	logic [63:0] cfg_img_len;
	logic        cfg_reloc;
	logic [63:0] cfg_base;

	// Span tracking of the image in flight
	logic [63:0] low_page;
	logic [63:0] high_end;
	logic        saw_load;
	logic        img_rejected;

	verdict_t expected_verdicts[$];
	int       bad_words;
	int       cycles;
	bit       stall_en;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** elf_segment_span_checker: FAILED **");
			$finish;
		end
	end

	// Result side: stall about a third of the cycles while stalls are on
	always @(posedge clk) begin
		res_ch.ready <= stall_en ? ($urandom_range(99) >= 33) : 1'b1;
	end

	// Result checker: each word against the oldest expectation
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_verdicts.size() == 0) begin
				bad_words++;
				if (bad_words <= MAX_SHOWN)
					$display("unexpected result word: acc=%0b start=%h end=%h bias=%h",
						res_ch.accepted, res_ch.span_start, res_ch.span_end,
						res_ch.reloc_bias);
			end else begin
				want = expected_verdicts.pop_front();
				if (res_ch.accepted !== want.accepted ||
					res_ch.span_start !== want.span_start ||
					res_ch.span_end !== want.span_end ||
					res_ch.reloc_bias !== want.reloc_bias) begin
					bad_words++;
					if (bad_words <= MAX_SHOWN) begin
						$display("result mismatch: expected acc=%0b start=%h end=%h bias=%h",
							want.accepted, want.span_start, want.span_end, want.reloc_bias);
						$display("                 actual   acc=%0b start=%h end=%h bias=%h",
							res_ch.accepted, res_ch.span_start, res_ch.span_end,
							res_ch.reloc_bias);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- prediction

	function automatic void clear_image();
		low_page     = esc_pkg::ALL_ONES;
		high_end     = '0;
		saw_load     = 1'b0;
		img_rejected = 1'b0;
	endfunction

	function automatic bit in_file(logic [63:0] off, logic [63:0] len);
		return off <= cfg_img_len && len <= cfg_img_len - off;
	endfunction

	// Checks one header and widens the span on a good loadable segment
	function automatic bit header_passes(hdr_word_t h);
		logic [63:0] lo;
		logic [63:0] hi;
		if (h.kind == esc_pkg::SEG_INTERP)
			return h.fbytes >= esc_pkg::INTERP_MIN && h.fbytes <= esc_pkg::INTERP_MAX &&
				in_file(h.off, h.fbytes);
		if (h.kind != esc_pkg::SEG_LOADABLE)
			return 1'b1;
		saw_load = 1'b1;
		if (h.mbytes < h.fbytes || !in_file(h.off, h.fbytes))
			return 1'b0;
		if (h.align > 64'd1 && (h.align & (h.align - 64'd1)) != 64'd0)
			return 1'b0;
		if ((h.vaddr & esc_pkg::PAGE_MASK) != (h.off & esc_pkg::PAGE_MASK))
			return 1'b0;
		if (h.vaddr > esc_pkg::ALL_ONES - h.mbytes)
			return 1'b0;
		lo = h.vaddr & ~esc_pkg::PAGE_MASK;
		hi = h.vaddr + h.mbytes;
		hi = (hi + esc_pkg::PAGE_MASK) & ~esc_pkg::PAGE_MASK;   // may wrap to zero
		if (lo < low_page)
			low_page = lo;
		if (hi > high_end)
			high_end = hi;
		return 1'b1;
	endfunction

	// Updates the image state; on the last header queues the verdict
	function automatic void span_predict(hdr_word_t h);
		verdict_t v;
		if (!img_rejected) begin
			if (!header_passes(h))
				img_rejected = 1'b1;
		end
		if (!h.last)
			return;
		v.accepted   = !img_rejected && saw_load && low_page != esc_pkg::ALL_ONES &&
			high_end > low_page;
		v.reloc_bias = '0;
		if (v.accepted) begin
			if (!cfg_reloc) begin
				if (low_page < esc_pkg::MIN_FIXED_START)
					v.accepted = 1'b0;
			end else if (cfg_base < low_page) begin
				v.accepted = 1'b0;
			end else begin
				v.reloc_bias = cfg_base - low_page;
			end
		end
		v.span_start = v.accepted ? low_page : '0;
		v.span_end   = v.accepted ? high_end : '0;
		expected_verdicts.push_back(v);
		clear_image();
	endfunction

	// ---------------------------------------------------------------- drivers

	// APB access; a write is read back and compared
	task automatic reg_access(input esc_pkg::esc_reg_t r, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			bad_words++;
			if (bad_words <= MAX_SHOWN)
				$display("register %s readback: expected %h, actual %h", r.name(), value,
					prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending and wait until every expected word is in
	task automatic settle();
		hdr_ch.valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [63:0] flen, input logic rel,
		input logic [63:0] base);
		settle();
		reg_access(esc_pkg::REG_IMG_LEN, flen);
		reg_access(esc_pkg::REG_RELOCATABLE, {63'd0, rel});
		reg_access(esc_pkg::REG_PREF_BASE, base);
		cfg_img_len = flen;
		cfg_reloc   = rel;
		cfg_base    = base;
	endtask

	// Sends one header word, with random idle cycles before it
	task automatic send_hdr(input hdr_word_t h);
		while (stall_en && $urandom_range(99) < 33) begin
			hdr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		hdr_ch.valid        <= 1'b1;
		hdr_ch.segment_type <= h.kind;
		hdr_ch.file_offset  <= h.off;
		hdr_ch.virt_addr    <= h.vaddr;
		hdr_ch.file_bytes   <= h.fbytes;
		hdr_ch.mem_bytes    <= h.mbytes;
		hdr_ch.alignment    <= h.align;
		hdr_ch.last         <= h.last;
		@(posedge clk);
		while (!hdr_ch.ready)
			@(posedge clk);
		span_predict(h);
	endtask

	// ---------------------------------------------------------------- header builders

	function automatic hdr_word_t hdr_word(logic [31:0] kind, logic [63:0] off,
		logic [63:0] va, logic [63:0] fb, logic [63:0] mb, logic [63:0] al, logic last);
		hdr_word_t h;
		h.kind   = kind;
		h.off    = off;
		h.vaddr  = va;
		h.fbytes = fb;
		h.mbytes = mb;
		h.align  = al;
		h.last   = last;
		return h;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_upto(logic [63:0] m);
		return (m == esc_pkg::ALL_ONES) ? rand64() : rand64() % (m + 64'd1);
	endfunction

	function automatic logic [63:0] min64(logic [63:0] a, logic [63:0] b);
		return (a < b) ? a : b;
	endfunction

	// Loadable segment that fits the current file length
	function automatic hdr_word_t good_load();
		hdr_word_t   h;
		logic [63:0] room;
		logic [63:0] page;
		h.kind   = esc_pkg::SEG_LOADABLE;
		h.last   = 1'b0;
		h.off    = rand_upto(min64(cfg_img_len, 64'h40_0000));
		room     = cfg_img_len - h.off;
		h.fbytes = rand_upto(min64(room, 64'h2_0000));
		h.mbytes = ($urandom_range(7) == 0) ? h.fbytes : h.fbytes + rand_upto(64'h3_0000);
		case ($urandom_range(9))
			0: page = '0;
			1: page = $urandom_range(15) * 64'h1000;
			2: page = esc_pkg::ALL_ONES - rand_upto(64'hF_FFFF);
			3: page = rand64();
			default: page = 64'h1_0000 + $urandom_range(20'hF_FFFF) * 64'h1000;
		endcase
		h.vaddr = (page & ~esc_pkg::PAGE_MASK) | (h.off & esc_pkg::PAGE_MASK);
		case ($urandom_range(3))
			0: h.align = '0;
			1: h.align = 64'd1;
			default: h.align = 64'd1 << $urandom_range(63);
		endcase
		return h;
	endfunction

	function automatic hdr_word_t make_header(hdr_style_t st);
		hdr_word_t   h;
		logic [63:0] room;
		int          k;
		case (st)
			HS_LOAD: h = good_load();
			HS_INTERP: begin
				h = hdr_word(esc_pkg::SEG_INTERP, '0, rand64(), $urandom_range(2, 256),
					rand64(), rand64(), 1'b0);
				if (cfg_img_len >= h.fbytes)
					h.off = rand_upto(min64(cfg_img_len - h.fbytes, 64'h40_0000));
			end
			HS_OTHER: begin
				h = hdr_word($urandom, rand64(), rand64(), rand64(), rand64(), rand64(), 1'b0);
				if (h.kind == esc_pkg::SEG_LOADABLE || h.kind == esc_pkg::SEG_INTERP)
					h.kind = 32'h6474_e551;
			end
			HS_BROKEN: begin
				h = good_load();
				case ($urandom_range(6))
					0: begin
						// memory smaller than file part
						if (h.fbytes == 0)
							h.fbytes = 64'd1;
						h.mbytes = h.fbytes - 64'd1 - rand_upto(h.fbytes - 64'd1);
					end
					1: begin
						// offset past the end of the file
						if (cfg_img_len != esc_pkg::ALL_ONES)
							h.off = cfg_img_len + 64'd1 + rand_upto(~cfg_img_len - 64'd1);
					end
					2: begin
						// file part runs past the end of the file
						room = cfg_img_len - h.off;
						if (room != esc_pkg::ALL_ONES) begin
							h.fbytes = room + 64'd1 + rand_upto(64'hFFFF);
							h.mbytes = h.fbytes;
						end
					end
					3: begin
						k       = $urandom_range(1, 63);
						h.align = (64'd1 << k) | (64'd1 << $urandom_range(k - 1));
					end
					4: h.vaddr ^= 64'd1 << $urandom_range(11);
					5: begin
						// address plus memory size overflows
						if (h.mbytes == 0)
							h.mbytes = 64'd1 + rand_upto(64'hFFFF);
						h.vaddr = esc_pkg::ALL_ONES - rand_upto(h.mbytes - 64'd1);
					end
					default: begin
						h.kind   = esc_pkg::SEG_INTERP;
						h.fbytes = $urandom_range(1) ? 64'd257 + rand_upto(64'hFFFF)
							: $urandom_range(1);
					end
				endcase
			end
			default: begin
				h = hdr_word($urandom, rand64(), rand64(), rand64(), rand64(), rand64(), 1'b0);
				case ($urandom_range(2))
					0: h.kind = esc_pkg::SEG_LOADABLE;
					1: h.kind = esc_pkg::SEG_INTERP;
					default: ;
				endcase
			end
		endcase
		return h;
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_directed_fixed();
		set_config(64'h20_0000, 1'b0, '0);
		// clean image with interpreter and an ignored header
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, 64'h0, 64'h40_0000, 64'h1000, 64'h1000,
			64'h1000, 1'b0));
		send_hdr(hdr_word(esc_pkg::SEG_INTERP, 64'h238, '0, 64'd28, 64'd28, 64'd1, 1'b0));
		send_hdr(hdr_word(32'h6474_e551, '0, '0, '0, '0, 64'd16, 1'b0));
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, 64'h1_1234, 64'h41_1234, 64'h800, 64'h3000,
			64'h20_0000, 1'b1));
		// first failure poisons the rest of the image
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, 64'h0, 64'h40_0000, 64'h100, 64'h80, '0,
			1'b0));
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, 64'h2000, 64'h40_2000, 64'h100, 64'h100,
			64'h1000, 1'b1));
		// no loadable segment
		send_hdr(hdr_word(esc_pkg::SEG_INTERP, '0, '0, 64'd2, 64'd2, '0, 1'b1));
		// fixed image below the minimum start
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, '0, 64'hF000, 64'h10, 64'h10, '0, 1'b1));
		// rejects caused by a single bad header
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, 64'h20_0001, 64'h40_0001, '0, '0, '0, 1'b1));
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, 64'h1F_F000, 64'h40_0000, 64'h2000, 64'h2000,
			'0, 1'b1));
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, '0, 64'h40_0000, 64'h10, 64'h10, 64'd3,
			1'b1));
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, '0, 64'h40_0010, 64'h10, 64'h10, '0, 1'b1));
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, 64'hFF0, esc_pkg::ALL_ONES - 64'hF, 64'h10,
			64'h20, '0, 1'b1));
		send_hdr(hdr_word(esc_pkg::SEG_INTERP, '0, '0, 64'd1, 64'd1, '0, 1'b0));
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, '0, 64'h40_0000, 64'h10, 64'h10, '0, 1'b1));
		send_hdr(hdr_word(esc_pkg::SEG_INTERP, '0, '0, 64'd257, 64'd257, '0, 1'b1));
		// interpreter at the file end; page end that wraps to zero
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, '0, 64'h40_0000, 64'h10, 64'h10,
			64'd1 << 63, 1'b0));
		send_hdr(hdr_word(esc_pkg::SEG_INTERP, 64'h1F_FF00, '0, 64'd256, 64'd256, '0, 1'b0));
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, '0, 64'hFFFF_FFFF_FFFF_F000, '0, 64'h800,
			'0, 1'b1));
		// empty span
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, '0, 64'h40_0000, '0, '0, '0, 1'b1));
	endtask

	task automatic test_directed_relocatable();
		set_config(esc_pkg::ALL_ONES, 1'b1, 64'h5555_0000_0000);
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, '0, '0, 64'h1000, 64'h1000, 64'h1000,
			1'b1));
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, 64'h123, 64'h7000_0123, 64'h10, 64'h10, '0,
			1'b1));
		// base below the span start, then a span starting at zero
		set_config(64'h10_0000, 1'b1, '0);
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, 64'h2000, 64'h2000, 64'h100, 64'h100, '0,
			1'b1));
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, '0, '0, 64'h100, 64'h100, '0, 1'b1));
		set_config(64'h10_0000, 1'b1, esc_pkg::ALL_ONES);
		send_hdr(hdr_word(esc_pkg::SEG_LOADABLE, '0, 64'h8000_0000_0000_0000, 64'h100,
			64'h100, '0, 1'b1));
	endtask

	// Random images in phases of different register settings
	task automatic test_random_images();
		int         sent;
		int         target;
		int         n;
		int         r;
		bit         dirty;
		hdr_style_t st;
		hdr_word_t  h;
		sent = 0;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_config(rand_upto(64'hFF_FFFF), 1'b0, rand64());
				1: set_config(esc_pkg::ALL_ONES, 1'b1, esc_pkg::ALL_ONES);
				2: set_config(rand_upto(64'hFF_FFFF), 1'b1, '0);
				3: set_config('0, 1'b0, rand64());
				4: set_config(rand_upto(64'h7F_FFFF), 1'b1, rand64());
				5: set_config(esc_pkg::ALL_ONES, 1'b0, '0);
				6: set_config(64'h1000, 1'b1, rand64());
				default: set_config(rand64(), 1'b0, rand64());
			endcase
			stall_en = (p != 4);   // one long stretch without idling
			target   = RANDOM_ITEMS * (p + 1) / 8;
			while (sent < target) begin
				n     = $urandom_range(1, 6);
				dirty = ($urandom_range(99) < 30);
				for (int i = 0; i < n; i++) begin
					r = $urandom_range(99);
					if (r < 65)
						st = HS_LOAD;
					else if (r < 78)
						st = HS_INTERP;
					else if (r < 86)
						st = HS_OTHER;
					else if (!dirty)
						st = HS_LOAD;
					else
						st = (r < 94) ? HS_BROKEN : HS_NOISE;
					h      = make_header(st);
					h.last = (i == n - 1);
					send_hdr(h);
					sent++;
				end
			end
		end
		stall_en = 1'b1;
	endtask

	// ---------------------------------------------------------------- main

	initial begin
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		hdr_ch.valid        <= 1'b0;
		hdr_ch.segment_type <= '0;
		hdr_ch.file_offset  <= '0;
		hdr_ch.virt_addr    <= '0;
		hdr_ch.file_bytes   <= '0;
		hdr_ch.mem_bytes    <= '0;
		hdr_ch.alignment    <= '0;
		hdr_ch.last         <= 1'b0;
		stall_en    = 1'b1;
		bad_words   = 0;
		cycles      = 0;
		cfg_img_len = '0;
		cfg_reloc   = 1'b0;
		cfg_base    = '0;
		clear_image();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_fixed();
		test_directed_relocatable();
		test_random_images();
		settle();

		if (bad_words == 0 && expected_verdicts.size() == 0)
			$display("** elf_segment_span_checker: PASSED **");
		else
			$display("** elf_segment_span_checker: FAILED **");
		$finish;
	end

endmodule
